### src/voxel_face_cull_mesher_unit_macros.svh
// ============================================================================
// voxel_face_cull_mesher_unit_macros.svh
// Assertion shorthands for the voxel face-cull mesher. Each macro expects
// clk and rst_n in scope and disables checking while reset is asserted.
// ============================================================================
`ifndef VOXEL_FACE_CULL_MESHER_UNIT_MACROS_SVH
`define VOXEL_FACE_CULL_MESHER_UNIT_MACROS_SVH

// same-cycle implication
`define VFC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vfc_pkg.sv
// ============================================================================
// vfc_pkg
// Shared types, codes and constant tables of the voxel face-cull mesher.
// ============================================================================
package vfc_pkg;

    // input field widths
    localparam int XZ_W    = 5;
    localparam int Y_W     = 4;
    localparam int KIND_W  = 3;
    localparam int COUNT_W = 17;
    localparam int INDEX_W = 16;

    // grid size, fixed by the coordinate field widths
    localparam int GRID_XZ = 32;
    localparam int GRID_Y  = 16;
    localparam int DEPTH   = GRID_XZ * GRID_Y * GRID_XZ;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [COUNT_W-1:0] CAP_LIMIT  = 17'd65536;
    localparam logic [KIND_W-1:0]  KIND_COUNT = 3'd6;
    localparam logic [KIND_W-1:0]  KIND_EMPTY = 3'd0;

    // world units per cell and texel span of one tile
    localparam int CELL_UNITS = 16;
    localparam int HALF_CELL  = CELL_UNITS / 2;
    localparam logic [7:0] TILE_SPAN = 8'd15;

    // last step of a face's six vertices
    localparam logic [2:0] STEP_LAST = 3'd5;
    localparam logic [2:0] FACE_LAST = 3'd5;

    // address unit direction: center cell or neighbor across face (dir - 1)
    localparam logic [2:0] DIR_CENTER = 3'd0;
    localparam logic [2:0] DIR_NX     = 3'd1;
    localparam logic [2:0] DIR_PX     = 3'd2;
    localparam logic [2:0] DIR_PY     = 3'd3;
    localparam logic [2:0] DIR_NY     = 3'd4;
    localparam logic [2:0] DIR_NZ     = 3'd5;
    localparam logic [2:0] DIR_PZ     = 3'd6;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_MESH    = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_EMIT
    } seq_state_t;

    typedef struct packed {
        logic [XZ_W-1:0]   x;
        logic [Y_W-1:0]    y;
        logic [XZ_W-1:0]   z;
        logic [KIND_W-1:0] kind;
    } cell_t;

    // one vertex request from the sequencer
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [2:0]         face;
        logic [2:0]         step;
        logic [INDEX_W-1:0] index;
    } emit_t;

    // corner offset signs per face and corner: {x, y, z}, 1 means plus
    localparam logic [2:0] CORNER_SIGN [6][4] = '{
        '{3'b000, 3'b001, 3'b010, 3'b011},
        '{3'b100, 3'b101, 3'b110, 3'b111},
        '{3'b010, 3'b011, 3'b110, 3'b111},
        '{3'b000, 3'b001, 3'b100, 3'b101},
        '{3'b000, 3'b010, 3'b100, 3'b110},
        '{3'b001, 3'b011, 3'b101, 3'b111}
    };

    // corner texture selects per face and corner: {u, v}
    localparam logic [1:0] CORNER_UV [6][4] = '{
        '{2'b00, 2'b10, 2'b01, 2'b11},
        '{2'b10, 2'b00, 2'b11, 2'b01},
        '{2'b01, 2'b00, 2'b11, 2'b10},
        '{2'b00, 2'b01, 2'b10, 2'b11},
        '{2'b00, 2'b01, 2'b10, 2'b11},
        '{2'b10, 2'b11, 2'b00, 2'b01}
    };

    // corner order of the two triangles, even and odd faces
    localparam logic [1:0] TRI_EVEN [6] = '{2'd0, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
    localparam logic [1:0] TRI_ODD  [6] = '{2'd0, 2'd3, 2'd1, 2'd0, 2'd2, 2'd3};

    // atlas tile per block kind and face: low nibble column, high nibble row
    localparam logic [7:0] KIND_TILE [6][6] = '{
        '{8'd0,  8'd0,  8'd0,  8'd0, 8'd0,  8'd0},
        '{8'd16, 8'd16, 8'd32, 8'd0, 8'd16, 8'd16},
        '{8'd1,  8'd1,  8'd1,  8'd1, 8'd1,  8'd1},
        '{8'd2,  8'd2,  8'd2,  8'd2, 8'd2,  8'd2},
        '{8'd3,  8'd3,  8'd3,  8'd3, 8'd3,  8'd3},
        '{8'd20, 8'd20, 8'd36, 8'd4, 8'd20, 8'd20}
    };

endpackage

### src/vfc_addr_unit.sv
// ============================================================================
// vfc_addr_unit
// Shared grid address unit: offsets the cell by one step toward a face,
// checks the bounds and forms the linear store address.
// ============================================================================
module vfc_addr_unit
    import vfc_pkg::*;
(
    input  cell_t             loc,
    input  logic [2:0]        dir,
    output logic [ADDR_W-1:0] addr,
    output logic              in_grid
);

    logic [XZ_W:0] nx;
    logic [Y_W:0]  ny;
    logic [XZ_W:0] nz;
    logic          under;

    // neighbor coordinate, one bit wider; a step below zero is flagged
    always_comb
    begin
        nx    = {1'b0, loc.x};
        ny    = {1'b0, loc.y};
        nz    = {1'b0, loc.z};
        under = 1'b0;
        unique case (dir)
            DIR_NX:
            begin
                nx    = nx - 1'b1;
                under = (loc.x == '0);
            end
            DIR_PX: nx = nx + 1'b1;
            DIR_PY: ny = ny + 1'b1;
            DIR_NY:
            begin
                ny    = ny - 1'b1;
                under = (loc.y == '0);
            end
            DIR_NZ:
            begin
                nz    = nz - 1'b1;
                under = (loc.z == '0);
            end
            DIR_PZ: nz = nz + 1'b1;
            default: ;
        endcase
    end

    // bounds and address: (x * GRID_Y + y) * GRID_XZ + z
    assign in_grid = !under && (int'(nx) < GRID_XZ) && (int'(ny) < GRID_Y)
                     && (int'(nz) < GRID_XZ);
    assign addr = ADDR_W'((int'(nx) * GRID_Y + int'(ny)) * GRID_XZ + int'(nz));

endmodule

### src/vfc_vertex_gen.sv
// ============================================================================
// vfc_vertex_gen
// Vertex field unit: position and texture coordinates of one corner of one
// face, from the corner, texture and tile tables.
// ============================================================================
module vfc_vertex_gen
    import vfc_pkg::*;
(
    input  cell_t              loc,
    input  logic [2:0]         face,
    input  logic [2:0]         step,
    output logic signed [9:0]  pos_x,
    output logic signed [8:0]  pos_y,
    output logic signed [9:0]  pos_z,
    output logic [7:0]         tex_u,
    output logic [7:0]         tex_v
);

    logic [1:0] corner;
    logic [2:0] sgn;
    logic [1:0] uv;
    logic [7:0] tile;

    // corner of this step, odd faces wind the other way
    assign corner = face[0] ? TRI_ODD[step] : TRI_EVEN[step];
    assign sgn    = CORNER_SIGN[face][corner];
    assign uv     = CORNER_UV[face][corner];
    assign tile   = KIND_TILE[loc.kind][face];

    // cell times CELL_UNITS, plus or minus half a cell
    assign pos_x = 10'(int'(loc.x) * CELL_UNITS + (sgn[2] ? HALF_CELL : -HALF_CELL));
    assign pos_y = 9'(int'(loc.y) * CELL_UNITS + (sgn[1] ? HALF_CELL : -HALF_CELL));
    assign pos_z = 10'(int'(loc.z) * CELL_UNITS + (sgn[0] ? HALF_CELL : -HALF_CELL));

    // 16-tile-wide atlas, 16 texels per tile
    assign tex_u = {tile[3:0], 4'h0} + (uv[1] ? TILE_SPAN : 8'd0);
    assign tex_v = {tile[7:4], 4'h0} + (uv[0] ? TILE_SPAN : 8'd0);

endmodule

### src/vfc_sequencer.sv
// ============================================================================
// vfc_sequencer
// Control sequencer with the voxel store: clearing pass, voxel writes,
// neighbor scan through the shared address unit and per-vertex issue.
// ============================================================================
`include "voxel_face_cull_mesher_unit_macros.svh"

module vfc_sequencer
    import vfc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  op_t                in_op,
    input  cell_t              in_cell,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    output emit_t              emit,
    input  logic               emit_ready,
    output cell_t              cur_cell
);

    logic [KIND_W-1:0] mem [DEPTH];

    seq_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    cell_t              cell_reg, cell_next;
    logic [2:0]         scan_idx_reg, scan_idx_next;
    logic [KIND_W-1:0]  ckind_reg, ckind_next;
    logic [5:0]         mask_reg, mask_next;
    logic [2:0]         face_reg, face_next;
    logic [2:0]         step_reg, step_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] cap_reg, cap_next;
    logic [KIND_W-1:0]  rdata_reg;
    logic               ing_q_reg;

    logic [2:0]         au_dir;
    logic [ADDR_W-1:0]  au_addr;
    logic               au_in_grid;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [KIND_W-1:0]  mem_wdata;
    logic [COUNT_W-1:0] cap_eff;
    logic [5:0]         rest;
    logic [5:0]         mask_scan;
    logic [KIND_W-1:0]  data_kind;
    logic               last_cond;
    logic               emit_fire;
    logic               fits;

    // lowest set face in a mask
    function automatic logic [2:0] lowest_face(input logic [5:0] m);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 5; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

    vfc_addr_unit u_addr (
        .loc     (cell_reg),
        .dir     (au_dir),
        .addr    (au_addr),
        .in_grid (au_in_grid)
    );

    // voxel store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[au_addr];
        ing_q_reg <= au_in_grid;
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            scan_idx_reg <= '0;
            ckind_reg    <= KIND_EMPTY;
            mask_reg     <= '0;
            face_reg     <= '0;
            step_reg     <= '0;
            count_reg    <= '0;
            cap_reg      <= CAP_LIMIT;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            scan_idx_reg <= scan_idx_next;
            ckind_reg    <= ckind_next;
            mask_reg     <= mask_next;
            face_reg     <= face_next;
            step_reg     <= step_next;
            count_reg    <= count_next;
            cap_reg      <= cap_next;
        end
    end

    // latched item, payload only
    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    // capacity register and derived checks
    assign cap_next  = cfg_we ? cfg_data : cap_reg;
    assign cap_eff   = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;
    assign rest      = mask_reg & ~(6'b1 << face_reg);
    assign last_cond = (rest == '0)
                       || (({1'b0, count_reg} + 18'd7) > {1'b0, cap_eff});
    assign fits      = ({1'b0, count_reg} + 18'd6) <= {1'b0, cap_eff};
    assign data_kind = ing_q_reg ? rdata_reg : KIND_EMPTY;

    assign emit.valid = (state_reg == ST_EMIT);
    assign emit.last  = (step_reg == STEP_LAST) && last_cond;
    assign emit.face  = face_reg;
    assign emit.step  = step_reg;
    assign emit.index = count_reg[INDEX_W-1:0];
    assign emit_fire  = emit.valid && emit_ready;
    assign in_ready   = (state_reg == ST_IDLE);

    // meshed cell with the kind read from the store
    assign cur_cell = '{x: cell_reg.x, y: cell_reg.y, z: cell_reg.z, kind: ckind_reg};

    // next state and outputs
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        cell_next     = cell_reg;
        scan_idx_next = scan_idx_reg;
        ckind_next    = ckind_reg;
        mask_next     = mask_reg;
        face_next     = face_reg;
        step_next     = step_reg;
        count_next    = count_reg;
        au_dir        = DIR_CENTER;
        mem_we        = 1'b0;
        mem_waddr     = au_addr;
        mem_wdata     = cell_reg.kind;
        mask_scan     = mask_reg;

        // exposed flag of the neighbor read in the previous cycle
        if (scan_idx_reg >= 3'd2)
        begin
            mask_scan[scan_idx_reg - 3'd2] = (data_kind == KIND_EMPTY);
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = KIND_EMPTY;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cell_next = in_cell;
                    unique case (in_op)
                        OP_WRITE:   state_next = ST_WRITE;
                        OP_MESH:
                        begin
                            state_next    = ST_SCAN;
                            scan_idx_next = '0;
                            ckind_next    = KIND_EMPTY;
                            mask_next     = '0;
                        end
                        OP_RESTART: count_next = '0;
                        default: ;
                    endcase
                end
            end
            ST_WRITE:
            begin
                mem_we     = au_in_grid && (cell_reg.kind < KIND_COUNT);
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                // read issue for center, then faces; capture trails the issue through the registered read
                au_dir        = scan_idx_reg;
                scan_idx_next = scan_idx_reg + 1'b1;
                mask_next     = mask_scan;
                if (scan_idx_reg == 3'd1)
                begin
                    ckind_next = data_kind;
                end
                if (scan_idx_reg == 3'd7)
                begin
                    face_next = lowest_face(mask_scan);
                    step_next = '0;
                    if ((ckind_reg != KIND_EMPTY) && (mask_scan != '0) && fits)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    count_next = count_reg + 1'b1;
                    step_next  = step_reg + 1'b1;
                    if (step_reg == STEP_LAST)
                    begin
                        step_next = '0;
                        mask_next = rest;
                        face_next = lowest_face(rest);
                        if (last_cond)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `VFC_ASSERT(a_no_accept_in_clear, state_reg == ST_CLEAR, !in_ready, "item taken during clear")
    `VFC_ASSERT(a_emit_within_cap, emit_fire, ({1'b0, count_reg} + 18'd1) <= {1'b0, cap_eff}, "vertex beyond capacity")
    `VFC_ASSERT(a_last_on_final_step, emit.valid && emit.last, step_reg == STEP_LAST, "last flag mid face")
    `VFC_ASSERT_NEXT(a_idle_after_last, emit_fire && emit.last, state_reg == ST_IDLE, "no return to idle")
    `VFC_ASSERT(a_face_in_mask, emit.valid, mask_reg[face_reg] && (face_reg <= FACE_LAST), "emitting unexposed face")

endmodule

### src/voxel_face_cull_mesher_unit.sv
// ============================================================================
// voxel_face_cull_mesher_unit
// Voxel face-cull mesher: keeps a grid of block kinds and a vertex count,
// emits six vertices for each exposed face of a meshed cell, within the capacity.
// ============================================================================
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: operation; tdata: cell, kind
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: vertex; tlast: last vertex
// cfg       in   cfg_wr_en                    cfg_wr_data: vertex capacity
//
// Mesh makes one store read per cycle for the center and six neighbors,
// then sends one vertex word per cycle unless m_axis stalls.
// After reset the store is cleared one entry a cycle, all GRID_XZ*GRID_Y*GRID_XZ
// entries (16384); s_axis_tready stays low meanwhile.
// A stalled m_axis holds the vertex word and pauses the sequencer.
// ============================================================================
module voxel_face_cull_mesher_unit
    import vfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] cell_x, [8:5] cell_y, [13:9] cell_z, [16:14] block_kind
    input  logic [23:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] vertex_index, [25:16] pos_x, [34:26] pos_y, [44:35] pos_z,
    // [52:45] tex_u, [60:53] tex_v, [63:61] face_normal
    output logic [63:0] m_axis_tdata,
    // last_vertex
    output logic        m_axis_tlast,
    input  logic        cfg_wr_en,
    input  logic [16:0] cfg_wr_data
);

    cell_t             in_cell;
    cell_t             cur_cell;
    emit_t             emit;
    logic              emit_ready;
    logic signed [9:0] pos_x;
    logic signed [8:0] pos_y;
    logic signed [9:0] pos_z;
    logic [7:0]        tex_u;
    logic [7:0]        tex_v;
    logic              out_valid_reg, out_valid_next;
    logic [63:0]       out_data_reg;
    logic              out_last_reg;

    assign in_cell.x    = s_axis_tdata[4:0];
    assign in_cell.y    = s_axis_tdata[8:5];
    assign in_cell.z    = s_axis_tdata[13:9];
    assign in_cell.kind = s_axis_tdata[16:14];

    vfc_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_op      (op_t'(s_axis_tuser)),
        .in_cell    (in_cell),
        .cfg_we     (cfg_wr_en),
        .cfg_data   (cfg_wr_data),
        .emit       (emit),
        .emit_ready (emit_ready),
        .cur_cell   (cur_cell)
    );

    vfc_vertex_gen u_vgen (
        .loc   (cur_cell),
        .face  (emit.face),
        .step  (emit.step),
        .pos_x (pos_x),
        .pos_y (pos_y),
        .pos_z (pos_z),
        .tex_u (tex_u),
        .tex_v (tex_v)
    );

    // output word register
    assign emit_ready     = !out_valid_reg || m_axis_tready;
    assign out_valid_next = (emit.valid && emit_ready)
                            || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid && emit_ready)
        begin
            out_data_reg <= {emit.face, tex_v, tex_u, pos_z, pos_y, pos_x, emit.index};
            out_last_reg <= emit.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
